@@ rtl/vaa_pkg.sv @@
`default_nettype none
package vaa_pkg;

  // Fixed geometry of the input item
  localparam int WORD_BITS   = 64;
  localparam int NUM_IN_WORDS = 4;
  localparam int IN_BITS     = WORD_BITS * NUM_IN_WORDS;
  localparam int SUB_LANES   = 8;   // narrowest lanes per 64-bit word
  localparam int IDX_BITS    = 5;
  localparam int CNT_BITS    = 6;   // lane count, up to 32
  localparam int VECTOR_BITS_DEF = 256;

  // Configuration register map (register index = paddr[3:2])
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_LANE_SIZE      = 2'd0,
    REG_SIGNED_COMPARE = 2'd1,
    REG_FIND_MAX       = 2'd2,
    REG_FULL_WIDTH     = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    LANE_8  = 2'd0,
    LANE_16 = 2'd1,
    LANE_32 = 2'd2,
    LANE_64 = 2'd3
  } lane_size_e;

  typedef struct packed {
    lane_size_e            lane_size;
    logic                  sgn;
    logic                  fmax;
    logic [CNT_BITS-1:0]   lane_cnt;
  } cfg_t;

  typedef struct packed {
    logic                  vld;
    logic [IDX_BITS-1:0]   idx;
    logic [WORD_BITS-1:0]  val;
  } cand_t;

  // Extend a narrow lane to 64 bits
  function automatic logic [WORD_BITS-1:0] ext8(logic [7:0] b, logic sgn);
    return {{(WORD_BITS-8){sgn & b[7]}}, b};
  endfunction

  function automatic logic [WORD_BITS-1:0] ext16(logic [15:0] b, logic sgn);
    return {{(WORD_BITS-16){sgn & b[15]}}, b};
  endfunction

  function automatic logic [WORD_BITS-1:0] ext32(logic [31:0] b, logic sgn);
    return {{(WORD_BITS-32){sgn & b[31]}}, b};
  endfunction

  // Keep a unless b is valid and either a is invalid or b is strictly better; a always has the lower index
  function automatic cand_t pick(cand_t a, cand_t b, logic fmax, logic sgn);
    logic [WORD_BITS-1:0] ka;
    logic [WORD_BITS-1:0] kb;
    logic                 take;
    ka   = {a.val[WORD_BITS-1] ^ sgn, a.val[WORD_BITS-2:0]};
    kb   = {b.val[WORD_BITS-1] ^ sgn, b.val[WORD_BITS-2:0]};
    take = b.vld && (!a.vld || (fmax ? (kb > ka) : (kb < ka)));
    return take ? b : a;
  endfunction

endpackage
`default_nettype wire

@@ rtl/vaa_in_if.sv @@
`default_nettype none
interface vaa_in_if import vaa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] word0;
  logic [WORD_BITS-1:0] word1;
  logic [WORD_BITS-1:0] word2;
  logic [WORD_BITS-1:0] word3;

  modport source (output valid, output word0, output word1, output word2, output word3,
                  input ready);
  modport sink   (input valid, input word0, input word1, input word2, input word3,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/vaa_out_if.sv @@
`default_nettype none
interface vaa_out_if import vaa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IDX_BITS-1:0]  lane_index;
  logic [WORD_BITS-1:0] lane_value;

  modport source (output valid, output lane_index, output lane_value, input ready);
  modport sink   (input valid, input lane_index, input lane_value, output ready);
endinterface
`default_nettype wire

@@ rtl/vaa_word_lane.sv @@
`default_nettype none
// One 64-bit word: split into lanes, reduce to the best lane in two stages.
module vaa_word_lane import vaa_pkg::*; #(
  parameter int WordId = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 adv_i,
  input  wire cfg_t                 cfg_i,
  input  wire logic [WORD_BITS-1:0] word_i,
  output cand_t                     best_o
);

  logic [7:0]  v8  [SUB_LANES];
  logic [15:0] v16 [SUB_LANES/2];
  logic [31:0] v32 [SUB_LANES/4];
  logic [IDX_BITS-1:0] base;
  cand_t cand [SUB_LANES];
  cand_t half_d [SUB_LANES/2];
  cand_t half_q [SUB_LANES/2];
  cand_t best_d;
  cand_t best_q;

  // Slice the word at every lane width
  always_comb begin
    for (int j = 0; j < SUB_LANES; j++) v8[j] = word_i[8*j +: 8];
    for (int j = 0; j < SUB_LANES/2; j++) v16[j] = word_i[16*j +: 16];
    for (int j = 0; j < SUB_LANES/4; j++) v32[j] = word_i[32*j +: 32];
  end

  // Global index of this word's first lane
  always_comb begin
    unique case (cfg_i.lane_size)
      LANE_8:  base = IDX_BITS'(WordId * 8);
      LANE_16: base = IDX_BITS'(WordId * 4);
      LANE_32: base = IDX_BITS'(WordId * 2);
      LANE_64: base = IDX_BITS'(WordId);
      default: base = '0;
    endcase
  end

  // Build the candidates of the selected width
  always_comb begin
    for (int j = 0; j < SUB_LANES; j++) begin
      cand[j].idx = base + IDX_BITS'(j);
      case (cfg_i.lane_size)
        LANE_8: begin
          cand[j].val = ext8(v8[j], cfg_i.sgn);
          cand[j].vld = 1'b1;
        end
        LANE_16: begin
          cand[j].val = ext16(v16[2'(j)], cfg_i.sgn);
          cand[j].vld = (j < SUB_LANES/2);
        end
        LANE_32: begin
          cand[j].val = ext32(v32[1'(j)], cfg_i.sgn);
          cand[j].vld = (j < SUB_LANES/4);
        end
        default: begin
          cand[j].val = word_i;
          cand[j].vld = (j == 0);
        end
      endcase
      cand[j].vld = cand[j].vld && ({1'b0, cand[j].idx} < cfg_i.lane_cnt);
    end
  end

  // First compare level
  always_comb begin
    for (int k = 0; k < SUB_LANES/2; k++)
      half_d[k] = pick(cand[2*k], cand[2*k+1], cfg_i.fmax, cfg_i.sgn);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) half_q <= half_d;
  end

  // Remaining two compare levels
  always_comb begin
    best_d = pick(pick(half_q[0], half_q[1], cfg_i.fmax, cfg_i.sgn),
                  pick(half_q[2], half_q[3], cfg_i.fmax, cfg_i.sgn),
                  cfg_i.fmax, cfg_i.sgn);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) best_q <= best_d;
  end

  assign best_o = best_q;

endmodule
`default_nettype wire

@@ rtl/vaa_merge.sv @@
`default_nettype none
// Combine the per-word winners; lower word wins ties.
module vaa_merge import vaa_pkg::*; #(
  parameter int NumWords = NUM_IN_WORDS
) (
  input  wire logic  clk_i,
  input  wire logic  adv_i,
  input  wire cfg_t  cfg_i,
  input  wire cand_t word_best_i [NumWords],
  output cand_t      best_o
);

  cand_t padded [NUM_IN_WORDS];
  cand_t best_d;
  cand_t best_q;

  // Fill absent words with invalid candidates
  always_comb begin
    for (int w = 0; w < NUM_IN_WORDS; w++) padded[w] = '0;
    for (int w = 0; w < NumWords; w++) padded[w] = word_best_i[w];
  end

  always_comb begin
    best_d = pick(pick(padded[0], padded[1], cfg_i.fmax, cfg_i.sgn),
                  pick(padded[2], padded[3], cfg_i.fmax, cfg_i.sgn),
                  cfg_i.fmax, cfg_i.sgn);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) best_q <= best_d;
  end

  assign best_o = best_q;

endmodule
`default_nettype wire

@@ rtl/vector_argmin_argmax.sv @@
// vector_argmin_argmax: index and value of the smallest or largest lane of a vector.
//
// Input item (in_i): four 64-bit words, word0 holding vector bits 63:0. Result
// item (res_o): lane_index (lowest lane holding the extreme) and lane_value,
// zero- or sign-extended to 64 bits. Both use valid/ready; a transfer happens
// on a clock edge with valid and ready high.
// Configuration goes through the APB port: lane_size at 0x0, signed_compare
// at 0x4, find_max at 0x8, full_width at 0xC. Write only while the block is idle.
// The pipeline holds three register stages, the first loaded at the edge that
// accepts the item. One lane unit per 64-bit word splits and compares its
// lanes over two register stages, then a merge stage picks among the words.
// Throughput is one item per cycle while res_o.ready does not stall the pipeline.
// When res_o.ready is low with a result waiting, the whole pipeline holds and
// in_i.ready drops in the same cycle; it comes back with res_o.ready.
// Reset empties the pipeline and loads lane_size=32 bits, unsigned, minimum,
// full width.
`default_nettype none
module vector_argmin_argmax import vaa_pkg::*; #(
  parameter int VECTOR_BITS = VECTOR_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  vaa_in_if.sink                        in_i,
  vaa_out_if.source                     res_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam int FullRaw  = (VECTOR_BITS > IN_BITS) ? IN_BITS : VECTOR_BITS;
  localparam int FullBits = (FullRaw < WORD_BITS) ? WORD_BITS : FullRaw;
  localparam int HalfRaw  = ((VECTOR_BITS / 2) > IN_BITS) ? IN_BITS : (VECTOR_BITS / 2);
  localparam int HalfBits = (HalfRaw < WORD_BITS) ? WORD_BITS : HalfRaw;
  localparam int NumWords = (FullBits + WORD_BITS - 1) / WORD_BITS;

  lane_size_e lane_size_q;
  logic       sgn_q;
  logic       fmax_q;
  logic       full_q;
  logic       cfg_wr;
  reg_idx_e   reg_idx;
  logic [CNT_BITS-1:0] lane_cnt;
  cfg_t       cfg;
  logic       v1_q, v2_q, v3_q;
  logic       adv;
  logic [WORD_BITS-1:0] words [NUM_IN_WORDS];
  cand_t      word_best [NumWords];
  cand_t      best;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_size_q <= LANE_32;
      sgn_q       <= 1'b0;
      fmax_q      <= 1'b0;
      full_q      <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LANE_SIZE:      lane_size_q <= lane_size_e'(pwdata[1:0]);
        REG_SIGNED_COMPARE: sgn_q       <= pwdata[0];
        REG_FIND_MAX:       fmax_q      <= pwdata[0];
        REG_FULL_WIDTH:     full_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_LANE_SIZE:      prdata[1:0] = lane_size_q;
      REG_SIGNED_COMPARE: prdata[0]   = sgn_q;
      REG_FIND_MAX:       prdata[0]   = fmax_q;
      REG_FULL_WIDTH:     prdata[0]   = full_q;
      default:            prdata      = '0;
    endcase
  end

  // Number of active lanes for the current width and lane size
  always_comb begin
    unique case (lane_size_q)
      LANE_8:  lane_cnt = full_q ? CNT_BITS'(FullBits / 8)  : CNT_BITS'(HalfBits / 8);
      LANE_16: lane_cnt = full_q ? CNT_BITS'(FullBits / 16) : CNT_BITS'(HalfBits / 16);
      LANE_32: lane_cnt = full_q ? CNT_BITS'(FullBits / 32) : CNT_BITS'(HalfBits / 32);
      LANE_64: lane_cnt = full_q ? CNT_BITS'(FullBits / 64) : CNT_BITS'(HalfBits / 64);
      default: lane_cnt = CNT_BITS'(1);
    endcase
  end

  assign cfg = '{lane_size: lane_size_q, sgn: sgn_q, fmax: fmax_q, lane_cnt: lane_cnt};

  // Pipeline control: advance unless a finished result is stalled
  assign adv        = !v3_q || res_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Lane units, one per word
  assign words[0] = in_i.word0;
  assign words[1] = in_i.word1;
  assign words[2] = in_i.word2;
  assign words[3] = in_i.word3;

  for (genvar w = 0; w < NumWords; w++) begin : g_lane
    vaa_word_lane #(.WordId(w)) u_lane (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .cfg_i  (cfg),
      .word_i (words[w]),
      .best_o (word_best[w])
    );
  end

  vaa_merge #(.NumWords(NumWords)) u_merge (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .cfg_i       (cfg),
    .word_best_i (word_best),
    .best_o      (best)
  );

  assign res_o.valid      = v3_q;
  assign res_o.lane_index = best.idx;
  assign res_o.lane_value = best.val;

`ifndef SYNTH
  // The winning lane lies inside the active lane range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ({1'b0, res_o.lane_index} < lane_cnt))
    else $error("lane_index beyond active lanes");

  // Unsigned 8-bit results carry no bits above the lane
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !sgn_q && lane_size_q == LANE_8) |-> (res_o.lane_value[63:8] == '0))
    else $error("unsigned 8-bit result not zero-extended");

  // A stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> (res_o.valid && $stable(res_o.lane_value)
                                       && $stable(res_o.lane_index)))
    else $error("stalled result changed");

  // An accepted item reaches the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted item lost");
`endif

endmodule
`default_nettype wire

@@ tb/sv/vector_argmin_argmax_tb.sv @@
`timescale 1ns / 100ps
module vector_argmin_argmax_tb;
  import vaa_pkg::*;

  localparam int VEC_BITS       = VECTOR_BITS_DEF;
  localparam int CLK_PERIOD     = 4;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 20;
  localparam int PHASE_ITEMS    = 92;
  localparam logic [7:0] EDGE_BYTES [5] = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01};

  typedef struct packed {
    logic [IDX_BITS-1:0]  idx;
    logic [WORD_BITS-1:0] val;
  } lane_pick_t;

  logic clk = 1'b0;
  logic rst_ni;

  vaa_in_if  in_bus();
  vaa_out_if res_bus();

  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  // Shadow copy of the mode registers
  lane_size_e cur_lane_size;
  logic       cur_signed;
  logic       cur_max;
  logic       cur_full;

  logic [IN_BITS-1:0] pending_vecs[$];
  lane_pick_t         predicted_picks[$];
  int                 mismatch_count;

  int burst_left;
  int gap_left;
  int hold_reqs;
  int hold_taken;
  int hold_left;
  int pattern_kind;
  int pattern_left;
  int quiet_cycles;

  vector_argmin_argmax #(
    .VECTOR_BITS(VEC_BITS)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .res_o  (res_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Lowest lane holding the min or max under the current mode
  function automatic lane_pick_t find_extreme_lane(logic [IN_BITS-1:0] vec);
    int unsigned        lane_w;
    int unsigned        span;
    int unsigned        lanes;
    logic [63:0]        mask;
    logic [63:0]        raw;
    logic [63:0]        key;
    logic [63:0]        best_key;
    logic [IN_BITS-1:0] shifted;
    lane_pick_t         best;
    lane_w = 8 << cur_lane_size;
    span = cur_full ? VEC_BITS : VEC_BITS / 2;
    if (span > IN_BITS) span = IN_BITS;
    if (span < WORD_BITS) span = WORD_BITS;
    lanes = span / lane_w;
    if (lanes == 0) lanes = 1;
    mask = (lane_w >= 64) ? '1 : ((64'd1 << lane_w) - 64'd1);
    best = '0;
    best_key = '0;
    for (int unsigned i = 0; i < lanes; i++) begin
      shifted = vec >> (i * lane_w);
      raw = shifted[63:0] & mask;
      if (cur_signed && raw[lane_w-1]) raw = raw | ~mask;
      // flip the sign bit so signed order becomes unsigned order
      key = {raw[63] ^ cur_signed, raw[62:0]};
      if (i == 0 || (cur_max ? (key > best_key) : (key < best_key))) begin
        best.idx = IDX_BITS'(i);
        best.val = raw;
        best_key = key;
      end
    end
    return best;
  endfunction

  function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
  endfunction

  // Random vector: plain noise, edge bytes, or a flat fill with a few outliers
  function automatic logic [IN_BITS-1:0] make_vector();
    logic [IN_BITS-1:0] v;
    int unsigned        style;
    logic [7:0]         fill;
    style = $urandom_range(0, 9);
    if (style < 4) begin
      for (int w = 0; w < NUM_IN_WORDS; w++) v[64*w +: 64] = {$urandom, $urandom};
    end else if (style < 7) begin
      for (int b = 0; b < IN_BITS / 8; b++) v[8*b +: 8] = EDGE_BYTES[$urandom_range(0, 4)];
    end else begin
      fill = 8'($urandom);
      for (int b = 0; b < IN_BITS / 8; b++) v[8*b +: 8] = fill;
      repeat ($urandom_range(1, 3)) v[8*$urandom_range(0, 31) +: 8] = 8'($urandom);
    end
    return v;
  endfunction

  // APB write: setup cycle, then access cycle until pready
  task automatic cfg_write(reg_idx_e r, logic [1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= ($urandom & ~32'h3) | {30'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_LANE_SIZE:      cur_lane_size = lane_size_e'(v);
      REG_SIGNED_COMPARE: cur_signed = v[0];
      REG_FIND_MAX:       cur_max = v[0];
      REG_FULL_WIDTH:     cur_full = v[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(lane_size_e ls, logic sgn, logic mx, logic fw);
    cfg_write(REG_LANE_SIZE, ls);
    cfg_write(REG_SIGNED_COMPARE, {1'b0, sgn});
    cfg_write(REG_FIND_MAX, {1'b0, mx});
    cfg_write(REG_FULL_WIDTH, {1'b0, fw});
  endtask

  // Wait until every item is sent and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_vecs.size() != 0 || in_bus.valid || predicted_picks.size() != 0);
  endtask

  // Sender: bursts of random length with random gaps
  always @(posedge clk) begin : drive
    logic [IN_BITS-1:0] sent;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        sent = pending_vecs.pop_front();
        predicted_picks.push_back(find_extreme_lane(sent));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left != 0) begin
          gap_left     <= gap_left - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_vecs.size() != 0) begin
          in_bus.valid <= 1'b1;
          in_bus.word0 <= pending_vecs[0][63:0];
          in_bus.word1 <= pending_vecs[0][127:64];
          in_bus.word2 <= pending_vecs[0][191:128];
          in_bus.word3 <= pending_vecs[0][255:192];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result, stall on a changing pattern or a long hold
  always @(posedge clk) begin : receive
    lane_pick_t want;
    logic       take;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      hold_left     <= 0;
      hold_taken    <= 0;
      pattern_kind  <= 0;
      pattern_left  <= 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (predicted_picks.size() == 0) begin
          flag_mismatch("unexpected result", '0, res_bus.lane_value);
        end else begin
          want = predicted_picks.pop_front();
          if (res_bus.lane_index !== want.idx)
            flag_mismatch("lane_index", 64'(want.idx), 64'(res_bus.lane_index));
          if (res_bus.lane_value !== want.val)
            flag_mismatch("lane_value", want.val, res_bus.lane_value);
        end
      end
      if (pattern_left == 0) begin
        pattern_kind <= $urandom_range(0, 3);
        pattern_left <= $urandom_range(8, 80);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      case (pattern_kind)
        0:       take = 1'b1;
        1:       take = ($urandom_range(0, 3) != 0);
        2:       take = ($urandom_range(0, 1) != 0);
        default: take = ($urandom_range(0, 7) == 0);
      endcase
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        take = 1'b0;
      end else if (hold_taken != hold_reqs) begin
        hold_taken <= hold_taken + 1;
        hold_left  <= HOLD_CYCLES;
        take = 1'b0;
      end
      res_bus.ready <= take;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("vector_argmin_argmax: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [IN_BITS-1:0] ramp;
    logic [IN_BITS-1:0] peak;
    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.word0   = '0;
    in_bus.word1   = '0;
    in_bus.word2   = '0;
    in_bus.word3   = '0;
    res_bus.ready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    hold_reqs      = 0;
    quiet_cycles   = 0;
    cur_lane_size  = LANE_32;
    cur_signed     = 1'b0;
    cur_max        = 1'b0;
    cur_full       = 1'b1;
    for (int b = 0; b < IN_BITS / 8; b++) ramp[8*b +: 8] = 8'(b);
    // top word holds negative lanes, the rest ties on the largest positive
    peak = {{8{8'h80}}, {24{8'h7f}}};

    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;

    // Directed: reset mode first, then each lane size under mixed modes
    @(negedge clk);
    pending_vecs.push_back('1);
    pending_vecs.push_back('0);
    wait_idle();
    for (int g = 0; g < 8; g++) begin
      set_mode(lane_size_e'(g[1:0]), g[2], g[0] ^ g[2], ~g[1]);
      @(negedge clk);
      pending_vecs.push_back('0);
      pending_vecs.push_back(peak);
      pending_vecs.push_back(ramp);
      wait_idle();
    end

    // Random: corner modes first, then random modes
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_mode(LANE_8, 1'b1, 1'b1, 1'b1);
        1:       set_mode(LANE_64, 1'b0, 1'b0, 1'b0);
        2:       set_mode(LANE_8, 1'b0, 1'b0, 1'b0);
        3:       set_mode(LANE_64, 1'b1, 1'b1, 1'b1);
        default: set_mode(lane_size_e'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      @(negedge clk);
      repeat (PHASE_ITEMS) pending_vecs.push_back(make_vector());
      // hold off the receiver while the sender keeps offering
      if (p == 6 || p == 14) hold_reqs++;
      wait_idle();
    end

    repeat (8) @(negedge clk);
    while (predicted_picks.size() != 0) begin
      flag_mismatch("missing result", predicted_picks[0].val, '0);
      void'(predicted_picks.pop_front());
    end
    if (mismatch_count == 0) begin
      $display("vector_argmin_argmax: match");
    end else begin
      $display("vector_argmin_argmax: mismatch");
    end
    $finish;
  end

endmodule
